@@ design/bnh_pkg.sv @@
// Shared constants and codes for the byte n-gram histogram.
package bnh_pkg;

	localparam int BYTE_W         = 8;
	localparam int IDX_W          = 16;
	localparam int COUNT_W        = 32;
	localparam int BLOCK_W        = 16;
	localparam int NGRAM_W        = 2;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 16;
	localparam int DEF_MAX_NGRAM  = 2;
	localparam int DEF_COUNT_BITS = 32;

	localparam logic [NGRAM_W-1:0] NGRAM_RESET = NGRAM_W'(1);
	localparam logic [BLOCK_W-1:0] BLOCK_RESET = BLOCK_W'(1024);

	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_READ  = 2'd1,
		KIND_CLEAR = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NGRAM_LEN = 2'd0,
		CFG_BLOCK_LEN = 2'd1
	} cfg_idx_t;

endpackage

@@ design/bnh_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module bnh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the old word when the same address is written in that cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ design/byte_ngram_histogram.sv @@
// Byte n-gram histogram: counter table in RAM, read-modify-write with forwarding.
//
// Stream bytes (kind 0) are taken one per cycle, back to back, including runs that hit
// the same counter: the counter RAM is read in the transfer cycle, incremented with
// saturation in the next cycle and written back, and the value written in the previous
// cycle is forwarded. A read (kind 1) goes through rd_s1 into the result register and
// is taken only once no earlier read result is pending, so a new read is not taken
// while the previous one is in flight. Clear (kind 2) and reset each start a clearing
// pass that writes one counter per cycle over all 2^(8*MAX_NGRAM) counters (65536 by
// default), during which no item is taken; configuration writes are taken at any time.
module byte_ngram_histogram #(
	parameter int MAX_NGRAM  = bnh_pkg::DEF_MAX_NGRAM,
	parameter int COUNT_BITS = bnh_pkg::DEF_COUNT_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_ready,
	input  logic [1:0]                       kind,
	input  logic [bnh_pkg::BYTE_W-1:0]       data_byte,
	input  logic [bnh_pkg::IDX_W-1:0]        bucket_index,
	output logic                             result_valid,
	input  logic                             result_ready,
	output logic [bnh_pkg::COUNT_W-1:0]      count_value,
	output logic [bnh_pkg::IDX_W-1:0]        bucket_echo,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bnh_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bnh_pkg::CFG_DATA_W-1:0]   cfg_data
);

	import bnh_pkg::*;

	localparam int ADDR_W = BYTE_W * MAX_NGRAM;
	localparam int DEPTH  = 1 << ADDR_W;

	logic [NGRAM_W-1:0]    ngram_len_q;
	logic [BLOCK_W-1:0]    block_len_q;
	logic [BYTE_W-1:0]     prev_byte_q;
	logic [BLOCK_W-1:0]    bib_q;

	logic                  clr_busy_q;
	logic [ADDR_W-1:0]     clr_addr_q;

	logic                  wr_s1;
	logic                  rd_s1;
	logic [ADDR_W-1:0]     idx_s1;

	logic                  fwd_valid_s2;
	logic [ADDR_W-1:0]     fwd_idx_s2;
	logic [COUNT_BITS-1:0] fwd_data_s2;

	logic                  result_valid_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [ADDR_W-1:0]     echo_q;

	logic                  accept;
	logic                  is_byte;
	logic                  is_read;
	logic                  is_clear;
	logic                  two_gram;
	logic                  blk_on;
	logic [BLOCK_W-1:0]    pos_cur;
	logic [BLOCK_W-1:0]    pos_inc;
	logic [BLOCK_W-1:0]    pos_next;
	logic                  counts;
	logic [2*BYTE_W-1:0]   window;
	logic [ADDR_W-1:0]     win_idx;
	logic [ADDR_W-1:0]     rd_addr;
	logic [COUNT_BITS-1:0] ram_rdata;
	logic [COUNT_BITS-1:0] cur_val;
	logic [COUNT_BITS-1:0] inc_val;
	logic                  ram_we;
	logic [ADDR_W-1:0]     ram_waddr;
	logic [COUNT_BITS-1:0] ram_wdata;

	assign is_byte  = (kind == KIND_BYTE);
	assign is_read  = (kind == KIND_READ);
	assign is_clear = (kind == KIND_CLEAR);

	// a read needs the result register free by the time its data arrives
	assign item_ready = !clr_busy_q && (!is_read || (!rd_s1 && (!result_valid_q || result_ready)));
	assign accept     = item_valid && item_ready;
	assign cfg_ready  = 1'b1;

	// block position and window
	assign two_gram = (MAX_NGRAM >= 2) && (ngram_len_q >= NGRAM_W'(2));
	assign blk_on   = (block_len_q != '0);
	assign pos_cur  = (blk_on && (bib_q >= block_len_q)) ? '0 : bib_q;
	assign pos_inc  = (pos_cur == '1) ? pos_cur : pos_cur + BLOCK_W'(1);
	assign pos_next = (blk_on && (pos_inc >= block_len_q)) ? '0 : pos_inc;
	assign counts   = !two_gram || (pos_cur != '0);
	assign window   = {data_byte, prev_byte_q};
	assign win_idx  = two_gram ? window[ADDR_W-1:0] : ADDR_W'(data_byte);
	assign rd_addr  = is_read ? bucket_index[ADDR_W-1:0] : win_idx;

	// saturating increment with forwarding of last cycle's write
	assign cur_val = (fwd_valid_s2 && (fwd_idx_s2 == idx_s1)) ? fwd_data_s2 : ram_rdata;
	assign inc_val = (cur_val == '1) ? cur_val : cur_val + COUNT_BITS'(1);

	assign ram_we    = clr_busy_q || wr_s1;
	assign ram_waddr = clr_busy_q ? clr_addr_q : idx_s1;
	assign ram_wdata = clr_busy_q ? '0 : inc_val;

	bnh_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (DEPTH)
	) u_counters (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ngram_len_q <= NGRAM_RESET;
			block_len_q <= BLOCK_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_NGRAM_LEN: ngram_len_q <= cfg_data[NGRAM_W-1:0];
				CFG_BLOCK_LEN: block_len_q <= cfg_data[BLOCK_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_byte_q <= '0;
			bib_q       <= '0;
		end else if (accept && is_byte) begin
			prev_byte_q <= data_byte;
			bib_q       <= pos_next;
		end
	end

	// clearing pass, one counter per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
			clr_busy_q <= (clr_addr_q != '1);
		end else if (accept && is_clear) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s1        <= 1'b0;
			rd_s1        <= 1'b0;
			fwd_valid_s2 <= 1'b0;
		end else begin
			wr_s1        <= accept && is_byte && counts;
			rd_s1        <= accept && is_read;
			fwd_valid_s2 <= wr_s1 && !clr_busy_q;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1      <= rd_addr;
		fwd_idx_s2  <= idx_s1;
		fwd_data_s2 <= inc_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (rd_s1) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_s1) begin
			count_q <= cur_val;
			echo_q  <= idx_s1;
		end
	end

	assign result_valid = result_valid_q;
	assign count_value  = COUNT_W'(count_q);
	assign bucket_echo  = IDX_W'(echo_q);

endmodule
